/* hw/rtl/iwc_pkg.sv */
// ----------------------------------------------------------------------------
// iwc_pkg
// Shared types and constants of the image window convolution block.
// ----------------------------------------------------------------------------
package iwc_pkg;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_RADIUS_DEF     = 4;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Field widths
    localparam int OP_W       = 2;
    localparam int PIX_W      = 8;
    localparam int CIDX_W     = 7;
    localparam int CVAL_W     = 17;
    localparam int ROW_W      = 16;
    localparam int S_DATA_W   = PIX_W + CIDX_W + CVAL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_WID_W  = 11;
    localparam int RAD_W      = 3;

    // Reset values of the registers
    localparam logic [CFG_WID_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [ROW_W-1:0]      HEIGHT_RST = 16'd1024;
    localparam logic [RAD_W-1:0]      RADIUS_RST = 3'd4;

    // Item kinds carried on tuser
    typedef enum logic [OP_W-1:0] {
        OP_COEF  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2
    } cfg_reg_t;

    // Window sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_WAIT,
        ST_MULT,
        ST_SUM,
        ST_ACC,
        ST_OUT
    } seq_state_t;

    // Controls broadcast to every cell of the row
    typedef struct packed {
        logic              shift;
        logic              mult;
        logic              sum;
        logic              load_en;
        logic [CIDX_W-1:0] load_idx;
        logic [CVAL_W-1:0] load_val;
    } cell_ctrl_t;

endpackage

/* hw/rtl/iwc_line_store.sv */
// ----------------------------------------------------------------------------
// iwc_line_store
// Line store of recent image rows: one write port, one registered read port.
// ----------------------------------------------------------------------------
module iwc_line_store #(
    parameter int DEPTH  = 10240,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write incoming pixels
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one window pixel per cycle while rd_en is high
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/iwc_cell.sv */
// ----------------------------------------------------------------------------
// iwc_cell
// One kernel column: holds its coefficients, one window pixel, a product
// and a partial sum, and hands pixel and partial sum to its neighbors.
// ----------------------------------------------------------------------------
module iwc_cell #(
    parameter int KSIDE    = 9,
    parameter int CELL_IDX = 0,
    parameter int KROW_W   = 4,
    parameter int ACC_W    = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  iwc_pkg::cell_ctrl_t      ctrl,
    input  logic [KROW_W-1:0]        row_sel,
    input  logic [iwc_pkg::PIX_W-1:0] pix_in,
    output logic [iwc_pkg::PIX_W-1:0] pix_out,
    input  logic [ACC_W-1:0]         psum_in,
    output logic [ACC_W-1:0]         psum_out
);
    import iwc_pkg::*;

    localparam int PROD_W = PIX_W + CVAL_W;

    logic [CVAL_W-1:0] coef_reg [KSIDE];
    logic [PIX_W-1:0]  pix_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  psum_reg;
    logic [CVAL_W-1:0] coef_sel;

    // Load coefficients of this column, one per kernel row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < KSIDE; d++) begin
                coef_reg[d] <= '0;
            end
        end else if (ctrl.load_en) begin
            for (int d = 0; d < KSIDE; d++) begin
                if (int'(ctrl.load_idx) == d * KSIDE + CELL_IDX) begin
                    coef_reg[d] <= ctrl.load_val;
                end
            end
        end
    end

    assign coef_sel = coef_reg[row_sel];

    // Shift pixels along the row, multiply, then ripple the partial sum
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            pix_reg <= pix_in;
        end
        if (ctrl.mult) begin
            prod_reg <= pix_reg * coef_sel;
        end
        if (ctrl.sum) begin
            psum_reg <= psum_in + ACC_W'(prod_reg);
        end
    end

    assign pix_out  = pix_reg;
    assign psum_out = psum_reg;

endmodule

/* hw/rtl/image_window_convolution_top.sv */
// ----------------------------------------------------------------------------
// image_window_convolution_top
// 2-D zero-padded convolution over a raster pixel stream, computed window by
// window on a row of multiply cells fed from a line store.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  s_      | in        | s_tvalid / s_tready | s_tdata, s_tuser (item kind)
//  m_      | out       | m_tvalid / m_tready | m_tdata, m_tlast (frame end)
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  A beat with no result leaves the sequencer idle (coefficient, unused kind,
//  pixel after a full frame) or passes through the check state only (pixel or
//  flush whose pending pixel is not ready). A beat that yields a result steps
//  through fetch, wait, multiply, sum and accumulate once per kernel row, then
//  output, KSIDE being 2*MAX_RADIUS+1: the single line store read port loads
//  KSIDE cells per kernel row, and the partial sum ripples through KSIDE cells.
//  The result sits in an output register, so a stalled m_ side holds only the
//  next result. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module image_window_convolution_top #(
    parameter int MAX_WIDTH      = iwc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS     = iwc_pkg::MAX_RADIUS_DEF,
    parameter int COEF_FRAC_BITS = iwc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: pixel_value, coef_index, coef_value
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [iwc_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: op
    input  logic [iwc_pkg::OP_W-1:0]          s_tuser,
    // m_tdata: filtered_pixel, out_column, out_row, zero fill
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((iwc_pkg::PIX_W + $clog2(MAX_WIDTH) + iwc_pkg::ROW_W + 7) / 8) * 8 - 1:0]
                                              m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [iwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iwc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import iwc_pkg::*;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WEFF_W     = COL_W + 1;
    localparam int KSIDE      = 2 * MAX_RADIUS + 1;
    localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int KCNT_W     = $clog2(KSIDE);
    localparam int ACC_W      = PIX_W + CVAL_W + $clog2(KSIDE * KSIDE);
    localparam int MEM_AW     = SLOT_W + COL_W;
    localparam int MEM_DEPTH  = STORE_ROWS * (2 ** COL_W);
    localparam int WX_W       = COL_W + 2;
    localparam int WY_W       = ROW_W + 2;
    localparam int OUT_W      = PIX_W + COL_W + ROW_W;
    localparam int M_DATA_W   = ((OUT_W + 7) / 8) * 8;

    // Configuration registers
    logic [CFG_WID_W-1:0] width_reg;
    logic [ROW_W-1:0]     height_reg;
    logic [RAD_W-1:0]     radius_reg;

    // Frame position state
    logic [COL_W-1:0]  in_col_reg, pend_col_reg;
    logic [ROW_W-1:0]  in_row_reg, pend_row_reg;
    logic [SLOT_W-1:0] in_slot_reg, pend_slot_reg;
    logic              frame_rcvd_reg;

    // Window sequencer
    seq_state_t               state_reg, state_next;
    logic [KCNT_W-1:0]        ky_reg, kcnt_reg;
    logic signed [WX_W-1:0]   wx_reg;
    logic signed [WY_W-1:0]   wy_reg;
    logic [SLOT_W-1:0]        wslot_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic                     rd_ok_reg, shift_reg;

    // Output register
    logic               m_tvalid_reg, m_last_reg;
    logic [PIX_W-1:0]   m_pix_reg;
    logic [COL_W-1:0]   m_col_reg;
    logic [ROW_W-1:0]   m_row_reg;

    // Decoded input beat
    op_t               s_op;
    logic [PIX_W-1:0]  s_pix;
    logic [CIDX_W-1:0] s_cidx;
    logic [CVAL_W-1:0] s_cval;
    logic              s_accept;

    // Effective register values
    logic [WEFF_W-1:0] w_eff, w_m1;
    logic [ROW_W-1:0]  h_eff, h_m1;
    logic [RAD_W-1:0]  r_eff;

    logic [ROW_W:0]    nr_raw;
    logic [ROW_W-1:0]  nr_c;
    logic [WEFF_W-1:0] nc_raw, nc_c;
    logic              pend_ready;
    logic              in_col_end, in_row_end, pend_col_end, pend_row_end;
    logic              out_free, out_load;
    logic              wx_ok, wy_ok, col_ok, last_kcnt, last_ky;
    logic signed [WX_W-1:0] wx_start;
    logic signed [WY_W-1:0] wy_start;
    logic [SLOT_W:0]   slot_raw;
    logic [SLOT_W-1:0] slot_start;
    logic [ACC_W-1:0]  acc_shift;
    logic [PIX_W-1:0]  sat_pix;

    // Cell row and line store connections
    cell_ctrl_t        cell_ctrl;
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [PIX_W-1:0]  mem_q, feed_pix;
    logic [PIX_W-1:0]  cell_pix [KSIDE];
    logic [ACC_W-1:0]  cell_psum [KSIDE];

    // Unpack the input beat
    assign s_op     = op_t'(s_tuser);
    assign s_pix    = s_tdata[PIX_W-1:0];
    assign s_cidx   = s_tdata[PIX_W +: CIDX_W];
    assign s_cval   = s_tdata[PIX_W + CIDX_W +: CVAL_W];
    assign s_accept = s_tvalid && s_tready;

    // Write configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            radius_reg <= RADIUS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data[CFG_WID_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                REG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp register values to the supported range
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WEFF_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;
        w_m1  = w_eff - WEFF_W'(1);
        h_m1  = h_eff - ROW_W'(1);
    end

    // Decide whether the pending pixel has its whole window
    always_comb begin
        nr_raw     = (ROW_W + 1)'(pend_row_reg) + (ROW_W + 1)'(r_eff);
        nr_c       = (nr_raw > (ROW_W + 1)'(h_m1)) ? h_m1 : nr_raw[ROW_W-1:0];
        nc_raw     = WEFF_W'(pend_col_reg) + WEFF_W'(r_eff);
        nc_c       = (nc_raw > w_m1) ? w_m1 : nc_raw;
        pend_ready = frame_rcvd_reg || (in_row_reg > nr_c) ||
                     ((in_row_reg == nr_c) && (WEFF_W'(in_col_reg) > nc_c));
    end

    // Row and column ends
    assign in_col_end   = (WEFF_W'(in_col_reg) + WEFF_W'(1)) >= w_eff;
    assign in_row_end   = ((ROW_W + 1)'(in_row_reg) + (ROW_W + 1)'(1)) >=
                          (ROW_W + 1)'(h_eff);
    assign pend_col_end = (WEFF_W'(pend_col_reg) + WEFF_W'(1)) >= w_eff;
    assign pend_row_end = ((ROW_W + 1)'(pend_row_reg) + (ROW_W + 1)'(1)) >=
                          (ROW_W + 1)'(h_eff);

    // Window geometry
    always_comb begin
        wx_start   = $signed(WX_W'(pend_col_reg)) - $signed(WX_W'(r_eff));
        wy_start   = $signed(WY_W'(pend_row_reg)) - $signed(WY_W'(r_eff));
        slot_raw   = (SLOT_W + 1)'(pend_slot_reg) + (SLOT_W + 1)'(STORE_ROWS) -
                     (SLOT_W + 1)'(r_eff);
        slot_start = (slot_raw >= (SLOT_W + 1)'(STORE_ROWS)) ?
                     SLOT_W'(slot_raw - (SLOT_W + 1)'(STORE_ROWS)) : SLOT_W'(slot_raw);
        wx_ok      = !wx_reg[WX_W-1] && (wx_reg < $signed(WX_W'(w_eff)));
        wy_ok      = !wy_reg[WY_W-1] && (wy_reg < $signed(WY_W'(h_eff)));
        col_ok     = (KCNT_W + 1)'(kcnt_reg) <= (KCNT_W + 1)'({r_eff, 1'b0});
        last_kcnt  = kcnt_reg == KCNT_W'(KSIDE - 1);
        last_ky    = (KCNT_W + 1)'(ky_reg) == (KCNT_W + 1)'({r_eff, 1'b0});
    end

    // Scale and saturate the window sum
    assign acc_shift = acc_reg >> COEF_FRAC_BITS;
    assign sat_pix   = (|acc_shift[ACC_W-1:PIX_W]) ? {PIX_W{1'b1}} : acc_shift[PIX_W-1:0];

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if ((s_op == OP_PIXEL && !frame_rcvd_reg) || s_op == OP_FLUSH) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: state_next = pend_ready ? ST_FETCH : ST_IDLE;
            ST_FETCH: begin
                if (last_kcnt) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_SUM;
            ST_SUM: begin
                if (last_kcnt) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:   state_next = last_ky ? ST_OUT : ST_FETCH;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready           = state_reg == ST_IDLE;
        mem_re             = state_reg == ST_FETCH;
        out_load           = (state_reg == ST_OUT) && out_free;
        mem_we             = s_accept && (s_op == OP_PIXEL) && !frame_rcvd_reg;
        cell_ctrl.shift    = shift_reg;
        cell_ctrl.mult     = state_reg == ST_MULT;
        cell_ctrl.sum      = state_reg == ST_SUM;
        cell_ctrl.load_en  = s_accept && (s_op == OP_COEF);
        cell_ctrl.load_idx = s_cidx;
        cell_ctrl.load_val = s_cval;
    end

    assign mem_waddr = {in_slot_reg, in_col_reg};
    assign mem_raddr = {wslot_reg, wx_reg[COL_W-1:0]};
    assign feed_pix  = rd_ok_reg ? mem_q : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance input and pending positions; wrap frame after its last result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_slot_reg    <= '0;
            pend_col_reg   <= '0;
            pend_row_reg   <= '0;
            pend_slot_reg  <= '0;
            frame_rcvd_reg <= 1'b0;
        end else if (out_load && pend_col_end && pend_row_end) begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_slot_reg    <= '0;
            pend_col_reg   <= '0;
            pend_row_reg   <= '0;
            pend_slot_reg  <= '0;
            frame_rcvd_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                if (in_col_end) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + ROW_W'(1);
                    in_slot_reg <= (in_slot_reg == SLOT_W'(STORE_ROWS - 1)) ?
                                   '0 : in_slot_reg + SLOT_W'(1);
                    if (in_row_end) begin
                        frame_rcvd_reg <= 1'b1;
                    end
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
            if (out_load) begin
                if (pend_col_end) begin
                    pend_col_reg  <= '0;
                    pend_row_reg  <= pend_row_reg + ROW_W'(1);
                    pend_slot_reg <= (pend_slot_reg == SLOT_W'(STORE_ROWS - 1)) ?
                                     '0 : pend_slot_reg + SLOT_W'(1);
                end else begin
                    pend_col_reg <= pend_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Step through window rows and columns
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ok_reg <= 1'b0;
            shift_reg <= 1'b0;
            kcnt_reg  <= '0;
            ky_reg    <= '0;
        end else begin
            shift_reg <= state_reg == ST_FETCH;
            rd_ok_reg <= (state_reg == ST_FETCH) && wx_ok && wy_ok && col_ok;
            case (state_reg)
                ST_CHECK: begin
                    kcnt_reg  <= '0;
                    ky_reg    <= '0;
                    wx_reg    <= wx_start;
                    wy_reg    <= wy_start;
                    wslot_reg <= slot_start;
                    acc_reg   <= '0;
                end
                ST_FETCH: begin
                    kcnt_reg <= last_kcnt ? '0 : kcnt_reg + KCNT_W'(1);
                    wx_reg   <= wx_reg + WX_W'(1);
                end
                ST_SUM: begin
                    kcnt_reg <= last_kcnt ? '0 : kcnt_reg + KCNT_W'(1);
                end
                ST_ACC: begin
                    acc_reg   <= acc_reg + cell_psum[KSIDE-1];
                    ky_reg    <= ky_reg + KCNT_W'(1);
                    wx_reg    <= wx_start;
                    wy_reg    <= wy_reg + WY_W'(1);
                    wslot_reg <= (wslot_reg == SLOT_W'(STORE_ROWS - 1)) ?
                                 '0 : wslot_reg + SLOT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Hold the result until the m_ side takes the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pix_reg  <= sat_pix;
            m_col_reg  <= pend_col_reg;
            m_row_reg  <= pend_row_reg;
            m_last_reg <= pend_col_end && pend_row_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(M_DATA_W - OUT_W)'(0), m_row_reg, m_col_reg, m_pix_reg};

    iwc_line_store #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (MEM_AW),
        .DATA_W (PIX_W)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (s_pix),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_q)
    );

    // Row of cells: pixels enter at the far end, partial sums leave there
    for (genvar i = 0; i < KSIDE; i++) begin : g_cell
        logic [PIX_W-1:0] pix_src;
        logic [ACC_W-1:0] psum_src;

        if (i == KSIDE - 1) begin : g_tail
            assign pix_src = feed_pix;
        end else begin : g_mid
            assign pix_src = cell_pix[i+1];
        end

        if (i == 0) begin : g_head
            assign psum_src = '0;
        end else begin : g_body
            assign psum_src = cell_psum[i-1];
        end

        iwc_cell #(
            .KSIDE    (KSIDE),
            .CELL_IDX (i),
            .KROW_W   (KCNT_W),
            .ACC_W    (ACC_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .row_sel  (ky_reg),
            .pix_in   (pix_src),
            .pix_out  (cell_pix[i]),
            .psum_in  (psum_src),
            .psum_out (cell_psum[i])
        );
    end

    // A new result appears only from the output state
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(m_tvalid_reg) && m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside output state");

    // A fully received frame has its input column back at zero
    a_frame_col: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_rcvd_reg |-> (in_col_reg == '0))
        else $error("input column not wrapped at frame end");

    // The pending pixel never runs ahead of the input
    a_pend_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        !frame_rcvd_reg |-> (pend_row_reg <= in_row_reg))
        else $error("pending row ahead of input row");

    // Window sequencing never starts without a completed check
    a_fetch_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_FETCH) |->
            ($past(state_reg) == ST_CHECK || $past(state_reg) == ST_ACC))
        else $error("window fetch entered from a wrong state");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for image_window_convolution_top: drives coefficient,
// pixel and flush beats over whole frames at several image and kernel sizes,
// mirrors the windowed convolution in a local model and checks every output
// beat against it, with random idle and stall bursts on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import iwc_pkg::*;

    localparam int KS     = 9;
    localparam int NROWS  = 10;
    localparam int MAXW   = 1024;
    localparam int WD_LIM = 4000;

    typedef struct {
        op_t         op;
        logic [7:0]  pix;
        logic [6:0]  cidx;
        logic [16:0] cval;
    } item_t;

    typedef struct {
        logic [7:0]  pix;
        logic [9:0]  col;
        logic [15:0] row;
        logic        last;
    } pixel_out_t;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast, cfg_valid, cfg_ready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0] s_tuser;
    logic [39:0] m_tdata;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    image_window_convolution_top dut (.*);

    // Local copy of the block state
    logic [7:0]  line_mem [0:NROWS-1][0:MAXW-1];
    logic [16:0] kernel [0:KS*KS-1];
    int unsigned in_col, in_row, pend_col, pend_row;
    bit          frame_done;
    logic [10:0] reg_width;
    logic [15:0] reg_height;
    logic [2:0]  reg_radius;

    item_t      pending_items[$];
    pixel_out_t filtered_q[$];
    item_t      cur_item;
    int         errors, results_seen, gap_left, stall_left, hold_left, quiet_cnt;
    bit         quiet, hold_req, hold_done;
    int         pixels_sent, frames_run, idle_cycles, items_sent;

    function automatic int unsigned eff_w();
        return reg_width == 0 ? 1 : (reg_width > MAXW ? MAXW : reg_width);
    endfunction

    function automatic int unsigned eff_h();
        return reg_height == 0 ? 1 : reg_height;
    endfunction

    function automatic int unsigned eff_r();
        return reg_radius > 4 ? 4 : reg_radius;
    endfunction

    function automatic logic [7:0] window_sum();
        int w, h, r, y, x;
        longint unsigned acc;
        w = eff_w(); h = eff_h(); r = eff_r(); acc = 0;
        for (int dy = -r; dy <= r; dy++) begin
            y = int'(pend_row) + dy;
            if (y < 0 || y >= h) continue;
            for (int dx = -r; dx <= r; dx++) begin
                x = int'(pend_col) + dx;
                if (x < 0 || x >= w) continue;
                acc += longint'(line_mem[y % NROWS][x % MAXW]) *
                       longint'(kernel[(dy + r) * KS + dx + r]);
            end
        end
        acc = acc >> 16;
        return acc > 255 ? 8'd255 : acc[7:0];
    endfunction

    // Emit the pending output pixel once its window is complete
    function automatic void emit_pending();
        int unsigned w, h, r, nr, nc;
        pixel_out_t e;
        w = eff_w(); h = eff_h(); r = eff_r();
        nr = pend_row + r; nc = pend_col + r;
        if (!frame_done) begin
            if (nr > h - 1) nr = h - 1;
            if (nc > w - 1) nc = w - 1;
            if (!(in_row > nr || (in_row == nr && in_col > nc))) return;
        end
        e.pix = window_sum();
        e.col = pend_col[9:0];
        e.row = pend_row[15:0];
        e.last = (pend_col + 1 >= w) && (pend_row + 1 >= h);
        filtered_q.push_back(e);
        if (e.last) begin
            in_col = 0; in_row = 0; pend_col = 0; pend_row = 0; frame_done = 0;
        end else if (pend_col + 1 >= w) begin
            pend_col = 0;
            pend_row = (pend_row + 1) & 16'hffff;
        end else begin
            pend_col++;
        end
    endfunction

    function automatic void conv_step(item_t it);
        case (it.op)
            OP_COEF: if (it.cidx < KS * KS) kernel[it.cidx] = it.cval;
            OP_PIXEL: if (!frame_done) begin
                line_mem[in_row % NROWS][in_col % MAXW] = it.pix;
                if (in_col + 1 >= eff_w()) begin
                    in_col = 0;
                    if (in_row + 1 >= eff_h()) frame_done = 1;
                    in_row = (in_row + 1) & 16'hffff;
                end else begin
                    in_col++;
                end
                emit_pending();
            end
            OP_FLUSH: emit_pending();
            default: ;
        endcase
    endfunction

    task automatic add_item(op_t op, int unsigned pix, int unsigned idx, int unsigned val);
        item_t it;
        it.op = op; it.pix = pix[7:0]; it.cidx = idx[6:0]; it.cval = val[16:0];
        pending_items.push_back(it);
        items_sent++;
        if (op == OP_PIXEL) pixels_sent++;
    endtask

    // Wait until every beat is out and the block has settled
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || filtered_q.size() != 0);
        repeat (400) @(posedge aclk);
    endtask

    // Offer one register write and hold it until taken
    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
    endtask

    task automatic set_regs(int unsigned w, int unsigned h, int unsigned r);
        write_reg(REG_WIDTH, w[15:0]);
        write_reg(REG_HEIGHT, h[15:0]);
        write_reg(REG_RADIUS, r[15:0]);
        cfg_valid <= 1'b0;
    endtask

    // Queue one frame: kernel load, pixels with scattered noise if noise is set, then flushes
    task automatic queue_frame(int unsigned w, int unsigned h, int unsigned r, bit noise);
        int unsigned side, cmax;
        side = 2 * r + 1;
        cmax = 131072 / (side * side);
        for (int i = 0; i < side; i++)
            for (int j = 0; j < side; j++)
                add_item(OP_COEF, $urandom, i * KS + j,
                         ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, cmax));
        for (int p = 0; p < w * h; p++) begin
            if (noise && $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: add_item(OP_FLUSH, $urandom, $urandom, $urandom);
                    1: add_item(OP_NONE, $urandom, $urandom, $urandom);
                    2: add_item(OP_COEF, $urandom, $urandom_range(81, 127), $urandom);
                    default: add_item(OP_COEF, $urandom, $urandom_range(0, 80),
                                      $urandom_range(0, cmax));
                endcase
            end
            add_item(OP_PIXEL, $urandom, $urandom, $urandom);
        end
        if (noise && $urandom_range(0, 2) == 0)
            add_item(OP_PIXEL, $urandom, $urandom, $urandom);
        repeat (r * (w + 1) + 2) add_item(OP_FLUSH, $urandom, $urandom, $urandom);
        frames_run++;
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Input driver: pops queued items, inserts idle bursts unless quiet
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) conv_step(cur_item);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    gap_left <= $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.cval, cur_item.cidx, cur_item.pix};
                    s_tuser  <= cur_item.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and ready generator
    always @(posedge aclk) begin
        pixel_out_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (filtered_q.size() == 0) begin
                    $error("output beat with no pending result");
                    errors++;
                end else begin
                    e = filtered_q.pop_front();
                    if (m_tdata[7:0] !== e.pix) begin
                        $error("filtered_pixel exp %0d got %0d", e.pix, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[17:8] !== e.col) begin
                        $error("out_column exp %0d got %0d", e.col, m_tdata[17:8]);
                        errors++;
                    end
                    if (m_tdata[33:18] !== e.row) begin
                        $error("out_row exp %0d got %0d", e.row, m_tdata[33:18]);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("frame_last exp %0d got %0d", e.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_left <= $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no beat moving anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIM) begin
            $display("image_window_convolution_top regression: fail");
            $finish;
        end
    end

    // Track register writes in the local copy
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WIDTH:  reg_width  = cfg_data[10:0];
                REG_HEIGHT: reg_height = cfg_data[15:0];
                REG_RADIUS: reg_radius = cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Stimulus sequence
    initial begin
        int unsigned w, h, r;
        aresetn = 1'b0;
        s_tdata = '0; s_tuser = '0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        errors = 0; results_seen = 0; pixels_sent = 0; frames_run = 0; idle_cycles = 0;
        items_sent = 0;
        quiet = 0; hold_req = 0; hold_done = 0; hold_left = 0;
        in_col = 0; in_row = 0; pend_col = 0; pend_row = 0; frame_done = 0;
        reg_width = WIDTH_RST; reg_height = HEIGHT_RST; reg_radius = RADIUS_RST;
        foreach (kernel[i]) kernel[i] = '0;
        foreach (line_mem[i, j]) line_mem[i][j] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: 4x3 frame, radius 1, kernel extremes and odd beats
        set_regs(4, 3, 1);
        add_item(OP_COEF, 0, 10, 65536);
        add_item(OP_COEF, 0, 0, 131071);
        add_item(OP_COEF, 0, 20, 32768);
        add_item(OP_COEF, 255, 127, 131071);
        add_item(OP_NONE, 255, 127, 131071);
        add_item(OP_FLUSH, 0, 0, 0);
        for (int p = 0; p < 12; p++)
            add_item(OP_PIXEL, (p % 3 == 0) ? 255 : (p % 3 == 1 ? 0 : 90), 0, 0);
        add_item(OP_PIXEL, 255, 0, 0);
        repeat (6) add_item(OP_FLUSH, 0, 0, 0);
        wait_idle();

        // Register extremes: zero size, largest radius code
        set_regs(0, 0, 7);
        queue_frame(1, 1, 4, 1);
        wait_idle();

        // Oversized width code, then the row is closed by a narrower width
        set_regs(2047, 1, 0);
        add_item(OP_COEF, 0, 0, 65536);
        for (int p = 0; p < 150; p++)
            add_item(OP_PIXEL, $urandom, 0, 0);
        add_item(OP_FLUSH, 0, 0, 0);
        wait_idle();
        set_regs(151, 1, 0);
        add_item(OP_PIXEL, $urandom, 0, 0);
        add_item(OP_FLUSH, 0, 0, 0);
        frames_run++;
        wait_idle();

        set_regs(1, 65535, 4);
        add_item(OP_COEF, 0, 80, 65536);
        add_item(OP_NONE, 0, 0, 0);
        wait_idle();

        // Random frames, the long output stall in the first of them
        while (items_sent < 480) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
            h = $urandom_range(1, 10);
            r = $urandom_range(0, 4);
            set_regs(w, h, r);
            if (!hold_done) hold_req = 1;
            queue_frame(w, h, r, 1);
            wait_idle();
        end

        // Closing frame with no idle on either side
        quiet = 1;
        w = $urandom_range(4, 12);
        h = $urandom_range(2, 5);
        r = $urandom_range(1, 4);
        set_regs(w, h, r);
        queue_frame(w, h, r, 0);
        wait_idle();

        $display("Covered %0d frames, %0d pixel beats, %0d output pixels checked.",
                 frames_run, pixels_sent, results_seen);
        $display("Kernels radius 0..4, register clamps, long output stall included.");
        if (errors == 0 && filtered_q.size() == 0) begin
            $display("image_window_convolution_top regression: pass");
        end else begin
            $display("image_window_convolution_top regression: fail");
        end
        $finish;
    end

endmodule
